// ----- src/psot_pkg.sv -----
// Package for the primitive shape overlap test: widths, opcodes and the
// stage record types of the pipeline. No dependencies.
package psot_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int PNT_W = COORD_WIDTH + 2;   // box corners need two more bits
   localparam int DIF_W = PNT_W + 1;
   localparam int PRD_W = 2 * DIF_W;
   localparam int SUM_W = PRD_W + 1;
   localparam int MAG_W = PRD_W;
   localparam int HLF_W = MAG_W / 2;
   localparam int WID_W = 2 * MAG_W;
   localparam int RAD_W = COORD_WIDTH - 1;
   localparam int RSQ_W = 2 * RAD_W;
   localparam int RSM_W = COORD_WIDTH;
   localparam int LIM_W = 2 * RSM_W + 1;
   localparam int REQ_DATA_W = 320;
   localparam int RSP_DATA_W = 8;

   localparam logic [3:0] OP_PT_CIRC   = 4'd0;
   localparam logic [3:0] OP_PT_RECT   = 4'd1;
   localparam logic [3:0] OP_PT_CAPS   = 4'd2;
   localparam logic [3:0] OP_RECT_RECT = 4'd3;
   localparam logic [3:0] OP_CIRC_CIRC = 4'd4;
   localparam logic [3:0] OP_CAPS_CAPS = 4'd5;
   localparam logic [3:0] OP_RECT_CIRC = 4'd6;
   localparam logic [3:0] OP_CAPS_CIRC = 4'd7;
   localparam logic [3:0] OP_CAPS_RECT = 4'd8;

   typedef logic signed [PNT_W-1:0] pnt_type;
   typedef logic signed [DIF_W-1:0] diff_type;
   typedef logic signed [PRD_W-1:0] prd_type;
   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic [MAG_W-1:0] mag_type;
   typedef logic [WID_W-1:0] wide_type;
   typedef logic [LIM_W-1:0] lim_type;

   typedef struct packed {
      pnt_type x;
      pnt_type y;
   } pt_type;

   typedef struct packed {
      pnt_type lx;
      pnt_type ly;
      pnt_type hx;
      pnt_type hy;
   } box_type;

   typedef struct packed {
      logic [3:0] op;
      pt_type a;
      pt_type b;
      pt_type c;
      pt_type d;
      box_type b1;
      box_type b2;
      logic [RSQ_W-1:0] r1sq;
      logic [RSQ_W-1:0] r2sq;
      logic [RSM_W-1:0] rs;
   } st1_type;

   typedef struct packed {
      diff_type ex;
      diff_type ey;
      diff_type qx;
      diff_type qy;
      diff_type wx;
      diff_type wy;
   } seg_diff_type;

   typedef struct packed {
      diff_type dx;
      diff_type dy;
   } rect_diff_type;

   typedef struct packed {
      diff_type ex;
      diff_type ey;
      diff_type qx;
      diff_type qy;
   } orn_diff_type;

   typedef struct packed {
      logic [3:0] op;
      seg_diff_type [3:0] sg;
      rect_diff_type [1:0] rc;
      orn_diff_type [3:0] orn;
      logic rr;
      logic bbox;
      logic [2*RSM_W-1:0] sum2;
      logic [RSQ_W-1:0] r1sq;
      logic [RSQ_W-1:0] r2sq;
   } st2_type;

   typedef struct packed {
      prd_type exx;
      prd_type eyy;
      prd_type qex;
      prd_type qey;
      prd_type qxey;
      prd_type qyex;
      prd_type qxx;
      prd_type qyy;
      prd_type wxx;
      prd_type wyy;
   } seg_prod_type;

   typedef struct packed {
      prd_type xx;
      prd_type yy;
   } rect_prod_type;

   typedef struct packed {
      prd_type eq;
      prd_type qe;
   } orn_prod_type;

   typedef struct packed {
      logic [3:0] op;
      seg_prod_type [3:0] sg;
      rect_prod_type [1:0] rc;
      orn_prod_type [3:0] orn;
      logic rr;
      logic bbox;
      lim_type slim;
      lim_type rlim;
   } st3_type;

   typedef struct packed {
      sum_type len;
      sum_type dt;
      sum_type dq;
      sum_type dw;
      mag_type cmag;
   } seg_sum_type;

   typedef struct packed {
      logic [3:0] op;
      seg_sum_type [3:0] sg;
      sum_type [1:0] rd2;
      logic [3:0] opos;
      logic [3:0] oneg;
      logic rr;
      logic bbox;
      lim_type slim;
      lim_type rlim;
   } st4_type;

   typedef struct packed {
      logic q_sel;
      logic w_sel;
      logic qok;
      logic wok;
      mag_type c_hh;
      mag_type c_hl;
      mag_type c_lh;
      mag_type c_ll;
      mag_type l_hh;
      mag_type l_hl;
      mag_type l_lh;
      mag_type l_ll;
   } seg_part_type;

   typedef struct packed {
      logic [3:0] op;
      seg_part_type [3:0] sg;
      logic [1:0] rok;
      logic [3:0] opos;
      logic [3:0] oneg;
      logic rr;
      logic bbox;
   } st5_type;

   typedef struct packed {
      logic q_sel;
      logic w_sel;
      logic qok;
      logic wok;
      wide_type c2;
      wide_type ll;
   } seg_cmp_type;

   typedef struct packed {
      logic [3:0] op;
      seg_cmp_type [3:0] sg;
      logic [1:0] rok;
      logic [3:0] opos;
      logic [3:0] oneg;
      logic rr;
      logic bbox;
   } st6_type;

endpackage

// ----- src/primitive_shape_overlap_test.sv -----
// Pairwise 2D shape overlap test: point, circle, rect and capsule pairs.
// Uses psot_pkg for widths, opcodes and the stage record types.
//
// Usage: an item on the req_ channel carries one pair test; the opcode travels
// on req_tuser and the two shapes on req_tdata. Each item yields exactly one
// result item on the rsp_ channel whose bit 0 is 1 when the closed shapes touch
// or overlap. Unknown opcodes answer 0.
// The pipeline takes one item per cycle while the output is not stalled; all
// tests are evaluated in parallel lanes (four point-segment lanes, two
// point-rect lanes, four orientation lanes), and the longest chain is the
// exact squared cross term, whose 70 by 70 bit products are formed from 35
// bit partial products in one stage and summed in the next.
// Reset clears only the stage valid bits; the pipeline is then empty and
// ready. When rsp_tready is low with a result waiting, every stage holds and
// req_tready drops, so no item is lost or repeated; gaps between items in the
// pipeline are not closed up while the output is stalled.
module primitive_shape_overlap_test
   import psot_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // first_x, first_y, first_u, first_v, first_radius, second_x, second_y,
   // second_u, second_v, second_radius, zero fill
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode
   input  logic [3:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // overlaps, zero fill
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [7:1] valid_ff, valid_in;
   logic       advance;

   st1_type st1_ff, st1_in;
   st2_type st2_ff, st2_in;
   st3_type st3_ff, st3_in;
   st4_type st4_ff, st4_in;
   st5_type st5_ff, st5_in;
   st6_type st6_ff, st6_in;
   logic    hit_ff, hit_in;

   pt_type  sp [4];
   pt_type  sa [4];
   pt_type  sb [4];
   pt_type  os [4];
   pt_type  ot [4];
   pt_type  oq [4];
   pt_type  kc [4];
   pt_type  rp [2];
   box_type rbox;
   logic [3:0] near;
   logic       xhit;

   function automatic pt_type get_pt(input logic [COORD_WIDTH-1:0] x,
                                     input logic [COORD_WIDTH-1:0] y);
      pt_type p;
      p.x = PNT_W'($signed(x));
      p.y = PNT_W'($signed(y));
      return p;
   endfunction

   function automatic box_type make_box(input pt_type c, input pnt_type u,
                                        input pnt_type v);
      pnt_type au;
      pnt_type av;
      box_type bx;
      au = (u < 0) ? -u : u;
      av = (v < 0) ? -v : v;
      bx.lx = c.x - au;
      bx.hx = c.x + au;
      bx.ly = c.y - av;
      bx.hy = c.y + av;
      return bx;
   endfunction

   function automatic diff_type sub(input pnt_type a, input pnt_type b);
      return DIF_W'(a) - DIF_W'(b);
   endfunction

   function automatic pnt_type clampv(input pnt_type p, input pnt_type lo,
                                      input pnt_type hi);
      pnt_type r;
      if (p < lo) begin
         r = lo;
      end else if (p > hi) begin
         r = hi;
      end else begin
         r = p;
      end
      return r;
   endfunction

   function automatic prd_type mul(input diff_type a, input diff_type b);
      return PRD_W'(a) * PRD_W'(b);
   endfunction

   function automatic mag_type pmul(input logic [HLF_W-1:0] a,
                                    input logic [HLF_W-1:0] b);
      return MAG_W'(a) * MAG_W'(b);
   endfunction

   function automatic wide_type psum(input mag_type hh, input mag_type hl,
                                     input mag_type lh, input mag_type ll);
      return (WID_W'(hh) << MAG_W) + (WID_W'(hl) << HLF_W) +
             (WID_W'(lh) << HLF_W) + WID_W'(ll);
   endfunction

   // The whole pipeline moves together whenever the output slot is free.
   assign advance    = !valid_ff[7] || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[7];
   assign rsp_tdata  = {{(RSP_DATA_W-1){1'b0}}, hit_ff};

   always_comb begin
      valid_in = {valid_ff[6:1], req_tvalid};
   end

   // Stage 1: unpack, build boxes, radius squares and radius sum.
   always_comb begin
      st1_in.op   = req_tuser;
      st1_in.a    = get_pt(req_tdata[31:0], req_tdata[63:32]);
      st1_in.b    = get_pt(req_tdata[95:64], req_tdata[127:96]);
      st1_in.c    = get_pt(req_tdata[190:159], req_tdata[222:191]);
      st1_in.d    = get_pt(req_tdata[254:223], req_tdata[286:255]);
      st1_in.b1   = make_box(st1_in.a, st1_in.b.x, st1_in.b.y);
      st1_in.b2   = make_box(st1_in.c, st1_in.d.x, st1_in.d.y);
      st1_in.r1sq = RSQ_W'(req_tdata[158:128]) * RSQ_W'(req_tdata[158:128]);
      st1_in.r2sq = RSQ_W'(req_tdata[317:287]) * RSQ_W'(req_tdata[317:287]);
      st1_in.rs   = RSM_W'(req_tdata[158:128]) + RSM_W'(req_tdata[317:287]);
   end

   // Stage 2: route shapes onto the lanes and form the differences.
   always_comb begin
      kc[0] = '{x: st1_ff.b2.lx, y: st1_ff.b2.ly};
      kc[1] = '{x: st1_ff.b2.hx, y: st1_ff.b2.ly};
      kc[2] = '{x: st1_ff.b2.hx, y: st1_ff.b2.hy};
      kc[3] = '{x: st1_ff.b2.lx, y: st1_ff.b2.hy};
      for (int i = 0; i < 4; i++) begin
         sp[i] = st1_ff.a;
         sa[i] = st1_ff.a;
         sb[i] = st1_ff.a;
         os[i] = st1_ff.a;
         ot[i] = st1_ff.a;
         oq[i] = st1_ff.a;
      end
      rp[0] = st1_ff.a;
      rp[1] = st1_ff.b;
      rbox  = st1_ff.b2;
      case (st1_ff.op)
         OP_PT_CIRC, OP_CIRC_CIRC: begin
            sa[0] = st1_ff.c;
            sb[0] = st1_ff.c;
         end
         OP_PT_CAPS: begin
            sa[0] = st1_ff.c;
            sb[0] = st1_ff.d;
         end
         OP_CAPS_CIRC: begin
            sp[0] = st1_ff.c;
            sb[0] = st1_ff.b;
         end
         OP_RECT_CIRC: begin
            rp[0] = st1_ff.c;
            rbox  = st1_ff.b1;
         end
         OP_CAPS_CAPS: begin
            sp[1] = st1_ff.b;
            sp[2] = st1_ff.c;
            sp[3] = st1_ff.d;
            sa[0] = st1_ff.c;
            sa[1] = st1_ff.c;
            sb[0] = st1_ff.d;
            sb[1] = st1_ff.d;
            sb[2] = st1_ff.b;
            sb[3] = st1_ff.b;
            ot[0] = st1_ff.b;
            ot[1] = st1_ff.b;
            oq[0] = st1_ff.c;
            oq[1] = st1_ff.d;
            os[2] = st1_ff.c;
            os[3] = st1_ff.c;
            ot[2] = st1_ff.d;
            ot[3] = st1_ff.d;
            oq[3] = st1_ff.b;
         end
         OP_CAPS_RECT: begin
            for (int i = 0; i < 4; i++) begin
               sp[i] = kc[i];
               sb[i] = st1_ff.b;
               ot[i] = st1_ff.b;
               oq[i] = kc[i];
            end
         end
         default: begin
         end
      endcase

      st2_in.op = st1_ff.op;
      for (int i = 0; i < 4; i++) begin
         st2_in.sg[i].ex  = sub(sb[i].x, sa[i].x);
         st2_in.sg[i].ey  = sub(sb[i].y, sa[i].y);
         st2_in.sg[i].qx  = sub(sp[i].x, sa[i].x);
         st2_in.sg[i].qy  = sub(sp[i].y, sa[i].y);
         st2_in.sg[i].wx  = sub(sp[i].x, sb[i].x);
         st2_in.sg[i].wy  = sub(sp[i].y, sb[i].y);
         st2_in.orn[i].ex = sub(ot[i].x, os[i].x);
         st2_in.orn[i].ey = sub(ot[i].y, os[i].y);
         st2_in.orn[i].qx = sub(oq[i].x, os[i].x);
         st2_in.orn[i].qy = sub(oq[i].y, os[i].y);
      end
      for (int i = 0; i < 2; i++) begin
         st2_in.rc[i].dx = sub(rp[i].x, clampv(rp[i].x, rbox.lx, rbox.hx));
         st2_in.rc[i].dy = sub(rp[i].y, clampv(rp[i].y, rbox.ly, rbox.hy));
      end
      st2_in.rr = ($signed(st1_ff.b1.lx) <= $signed(st1_ff.b2.hx)) &&
                  ($signed(st1_ff.b2.lx) <= $signed(st1_ff.b1.hx)) &&
                  ($signed(st1_ff.b1.ly) <= $signed(st1_ff.b2.hy)) &&
                  ($signed(st1_ff.b2.ly) <= $signed(st1_ff.b1.hy));
      // Bounding range of the capsule segment against the rect.
      st2_in.bbox =
         ((($signed(st1_ff.a.x) < $signed(st1_ff.b.x)) ? $signed(st1_ff.a.x)
            : $signed(st1_ff.b.x)) <= $signed(st1_ff.b2.hx)) &&
         ((($signed(st1_ff.a.x) > $signed(st1_ff.b.x)) ? $signed(st1_ff.a.x)
            : $signed(st1_ff.b.x)) >= $signed(st1_ff.b2.lx)) &&
         ((($signed(st1_ff.a.y) < $signed(st1_ff.b.y)) ? $signed(st1_ff.a.y)
            : $signed(st1_ff.b.y)) <= $signed(st1_ff.b2.hy)) &&
         ((($signed(st1_ff.a.y) > $signed(st1_ff.b.y)) ? $signed(st1_ff.a.y)
            : $signed(st1_ff.b.y)) >= $signed(st1_ff.b2.ly));
      st2_in.sum2 = (2*RSM_W)'(st1_ff.rs) * (2*RSM_W)'(st1_ff.rs);
      st2_in.r1sq = st1_ff.r1sq;
      st2_in.r2sq = st1_ff.r2sq;
   end

   // Stage 3: all lane products, and the limits each lane compares against.
   always_comb begin
      st3_in.op = st2_ff.op;
      for (int i = 0; i < 4; i++) begin
         st3_in.sg[i].exx  = mul(st2_ff.sg[i].ex, st2_ff.sg[i].ex);
         st3_in.sg[i].eyy  = mul(st2_ff.sg[i].ey, st2_ff.sg[i].ey);
         st3_in.sg[i].qex  = mul(st2_ff.sg[i].qx, st2_ff.sg[i].ex);
         st3_in.sg[i].qey  = mul(st2_ff.sg[i].qy, st2_ff.sg[i].ey);
         st3_in.sg[i].qxey = mul(st2_ff.sg[i].qx, st2_ff.sg[i].ey);
         st3_in.sg[i].qyex = mul(st2_ff.sg[i].qy, st2_ff.sg[i].ex);
         st3_in.sg[i].qxx  = mul(st2_ff.sg[i].qx, st2_ff.sg[i].qx);
         st3_in.sg[i].qyy  = mul(st2_ff.sg[i].qy, st2_ff.sg[i].qy);
         st3_in.sg[i].wxx  = mul(st2_ff.sg[i].wx, st2_ff.sg[i].wx);
         st3_in.sg[i].wyy  = mul(st2_ff.sg[i].wy, st2_ff.sg[i].wy);
         st3_in.orn[i].eq  = mul(st2_ff.orn[i].ex, st2_ff.orn[i].qy);
         st3_in.orn[i].qe  = mul(st2_ff.orn[i].ey, st2_ff.orn[i].qx);
      end
      for (int i = 0; i < 2; i++) begin
         st3_in.rc[i].xx = mul(st2_ff.rc[i].dx, st2_ff.rc[i].dx);
         st3_in.rc[i].yy = mul(st2_ff.rc[i].dy, st2_ff.rc[i].dy);
      end
      st3_in.rr   = st2_ff.rr;
      st3_in.bbox = st2_ff.bbox;
      case (st2_ff.op)
         OP_PT_CIRC, OP_PT_CAPS: st3_in.slim = LIM_W'(st2_ff.r2sq);
         OP_CIRC_CIRC, OP_CAPS_CAPS, OP_CAPS_CIRC: st3_in.slim = LIM_W'(st2_ff.sum2);
         OP_CAPS_RECT: st3_in.slim = LIM_W'(st2_ff.r1sq);
         default: st3_in.slim = '0;
      endcase
      case (st2_ff.op)
         OP_RECT_CIRC: st3_in.rlim = LIM_W'(st2_ff.r2sq);
         OP_CAPS_RECT: st3_in.rlim = LIM_W'(st2_ff.r1sq);
         default: st3_in.rlim = '0;
      endcase
   end

   // Stage 4: sums of products, cross magnitude, orientation signs.
   always_comb begin
      sum_type cr;
      st4_in.op = st3_ff.op;
      for (int i = 0; i < 4; i++) begin
         st4_in.sg[i].len = SUM_W'($signed(st3_ff.sg[i].exx)) +
                            SUM_W'($signed(st3_ff.sg[i].eyy));
         st4_in.sg[i].dt  = SUM_W'($signed(st3_ff.sg[i].qex)) +
                            SUM_W'($signed(st3_ff.sg[i].qey));
         st4_in.sg[i].dq  = SUM_W'($signed(st3_ff.sg[i].qxx)) +
                            SUM_W'($signed(st3_ff.sg[i].qyy));
         st4_in.sg[i].dw  = SUM_W'($signed(st3_ff.sg[i].wxx)) +
                            SUM_W'($signed(st3_ff.sg[i].wyy));
         cr = SUM_W'($signed(st3_ff.sg[i].qxey)) - SUM_W'($signed(st3_ff.sg[i].qyex));
         st4_in.sg[i].cmag = cr[SUM_W-1] ? MAG_W'(-cr) : MAG_W'(cr);
         st4_in.opos[i] = $signed(st3_ff.orn[i].eq) > $signed(st3_ff.orn[i].qe);
         st4_in.oneg[i] = $signed(st3_ff.orn[i].eq) < $signed(st3_ff.orn[i].qe);
      end
      for (int i = 0; i < 2; i++) begin
         st4_in.rd2[i] = SUM_W'($signed(st3_ff.rc[i].xx)) +
                         SUM_W'($signed(st3_ff.rc[i].yy));
      end
      st4_in.rr   = st3_ff.rr;
      st4_in.bbox = st3_ff.bbox;
      st4_in.slim = st3_ff.slim;
      st4_in.rlim = st3_ff.rlim;
   end

   // Stage 5: endpoint decisions and the partial products of the exact
   // comparison cross^2 <= limit * length^2.
   always_comb begin
      mag_type cm;
      mag_type lm;
      mag_type ln;
      st5_in.op = st4_ff.op;
      lm = MAG_W'(st4_ff.slim);
      for (int i = 0; i < 4; i++) begin
         cm = st4_ff.sg[i].cmag;
         ln = MAG_W'(st4_ff.sg[i].len);
         st5_in.sg[i].q_sel = (st4_ff.sg[i].len == '0) || !($signed(st4_ff.sg[i].dt) > 0);
         st5_in.sg[i].w_sel = $signed(st4_ff.sg[i].len) <= $signed(st4_ff.sg[i].dt);
         st5_in.sg[i].qok   = $unsigned(st4_ff.sg[i].dq) <= SUM_W'(st4_ff.slim);
         st5_in.sg[i].wok   = $unsigned(st4_ff.sg[i].dw) <= SUM_W'(st4_ff.slim);
         st5_in.sg[i].c_hh  = pmul(cm[MAG_W-1:HLF_W], cm[MAG_W-1:HLF_W]);
         st5_in.sg[i].c_hl  = pmul(cm[MAG_W-1:HLF_W], cm[HLF_W-1:0]);
         st5_in.sg[i].c_lh  = pmul(cm[HLF_W-1:0], cm[MAG_W-1:HLF_W]);
         st5_in.sg[i].c_ll  = pmul(cm[HLF_W-1:0], cm[HLF_W-1:0]);
         st5_in.sg[i].l_hh  = pmul(lm[MAG_W-1:HLF_W], ln[MAG_W-1:HLF_W]);
         st5_in.sg[i].l_hl  = pmul(lm[MAG_W-1:HLF_W], ln[HLF_W-1:0]);
         st5_in.sg[i].l_lh  = pmul(lm[HLF_W-1:0], ln[MAG_W-1:HLF_W]);
         st5_in.sg[i].l_ll  = pmul(lm[HLF_W-1:0], ln[HLF_W-1:0]);
      end
      for (int i = 0; i < 2; i++) begin
         st5_in.rok[i] = $unsigned(st4_ff.rd2[i]) <= SUM_W'(st4_ff.rlim);
      end
      st5_in.opos = st4_ff.opos;
      st5_in.oneg = st4_ff.oneg;
      st5_in.rr   = st4_ff.rr;
      st5_in.bbox = st4_ff.bbox;
   end

   // Stage 6: assemble the wide products.
   always_comb begin
      st6_in.op = st5_ff.op;
      for (int i = 0; i < 4; i++) begin
         st6_in.sg[i].q_sel = st5_ff.sg[i].q_sel;
         st6_in.sg[i].w_sel = st5_ff.sg[i].w_sel;
         st6_in.sg[i].qok   = st5_ff.sg[i].qok;
         st6_in.sg[i].wok   = st5_ff.sg[i].wok;
         st6_in.sg[i].c2    = psum(st5_ff.sg[i].c_hh, st5_ff.sg[i].c_hl,
                                   st5_ff.sg[i].c_lh, st5_ff.sg[i].c_ll);
         st6_in.sg[i].ll    = psum(st5_ff.sg[i].l_hh, st5_ff.sg[i].l_hl,
                                   st5_ff.sg[i].l_lh, st5_ff.sg[i].l_ll);
      end
      st6_in.rok  = st5_ff.rok;
      st6_in.opos = st5_ff.opos;
      st6_in.oneg = st5_ff.oneg;
      st6_in.rr   = st5_ff.rr;
      st6_in.bbox = st5_ff.bbox;
   end

   // Stage 7: finish each point-segment lane and pick the answer by opcode.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         if (st6_ff.sg[i].q_sel) begin
            near[i] = st6_ff.sg[i].qok;
         end else if (st6_ff.sg[i].w_sel) begin
            near[i] = st6_ff.sg[i].wok;
         end else begin
            near[i] = st6_ff.sg[i].c2 <= st6_ff.sg[i].ll;
         end
      end
      // Proper crossing: each segment's endpoints lie strictly on both sides.
      xhit = ((st6_ff.opos[0] && st6_ff.oneg[1]) || (st6_ff.oneg[0] && st6_ff.opos[1])) &&
             ((st6_ff.opos[2] && st6_ff.oneg[3]) || (st6_ff.oneg[2] && st6_ff.opos[3]));
      case (st6_ff.op)
         OP_PT_CIRC, OP_PT_CAPS, OP_CIRC_CIRC, OP_CAPS_CIRC: hit_in = near[0];
         OP_PT_RECT, OP_RECT_CIRC: hit_in = st6_ff.rok[0];
         OP_RECT_RECT: hit_in = st6_ff.rr;
         OP_CAPS_CAPS: hit_in = xhit || (|near);
         OP_CAPS_RECT: begin
            hit_in = (st6_ff.bbox && !(&st6_ff.opos) && !(&st6_ff.oneg)) ||
                     (|st6_ff.rok) || (|near);
         end
         default: hit_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
         st3_ff <= st3_in;
         st4_ff <= st4_in;
         st5_ff <= st5_in;
         st6_ff <= st6_in;
         hit_ff <= hit_in;
      end
   end

endmodule
